// ----- rtl/hhc_pkg.sv -----
`default_nettype none

package hhc_pkg;

   // field and datapath widths
   localparam int HEIGHT_W = 32;
   localparam int DIFF_W   = HEIGHT_W + 1;
   localparam int REM_W    = DIFF_W + 1;
   localparam int FRAC_W   = 16;
   localparam int UNIT_W   = FRAC_W + 1;
   localparam int SCALE_W  = 16;
   localparam int PROD_W   = UNIT_W + SCALE_W;
   localparam int SCALE_FB = 15;
   localparam int H6_W     = FRAC_W + 3;
   localparam int CHAN_W   = 8;
   localparam int CHAN_FW  = UNIT_W + CHAN_W;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   // one in Q1.16 and the channel extremes
   localparam logic [UNIT_W-1:0] FRAC_ONE  = UNIT_W'(1) << FRAC_W;
   localparam logic [CHAN_W-1:0] CHAN_FULL = '1;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;

   // fallback colour for a zero height range
   localparam logic [CHAN_W-1:0] FB_RED   = CHAN_W'(255);
   localparam logic [CHAN_W-1:0] FB_GREEN = CHAN_W'(128);
   localparam logic [CHAN_W-1:0] FB_BLUE  = CHAN_W'(128);

   // register reset values
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN_RST = HEIGHT_W'(0);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX_RST = HEIGHT_W'(65536);
   localparam logic [SCALE_W-1:0]  HUE_SCALE_RST  = SCALE_W'(26214);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEIGHT_MIN = 2'd0,
      CSR_HEIGHT_MAX = 2'd1,
      CSR_HUE_SCALE  = 2'd2
   } csr_index_type;

   // hue wheel sectors, in order of rising hue
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   // special cases that travel with an item
   typedef struct packed {
      logic zero_range;
      logic t_zero;
      logic sat;
   } flags_type;

endpackage

`default_nettype wire

// ----- rtl/hhc_if.sv -----
`default_nettype none

interface hhc_req_if;
   import hhc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [HEIGHT_W-1:0] height;

   modport source (output valid, output height, input ready);
   modport sink   (input valid, input height, output ready);
endinterface

interface hhc_rsp_if;
   import hhc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              range_error;

   modport source (output valid, output red, output green, output blue,
                   output range_error, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input range_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/hhc_csr.sv -----
`default_nettype none

module hhc_csr
   import hhc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output      logic [CSR_DATA_W-1:0]  prdata,
   output      logic                   pready,
   output      logic [HEIGHT_W-1:0]    height_min,
   output      logic [HEIGHT_W-1:0]    height_max,
   output      logic [SCALE_W-1:0]     hue_scale
);

   logic                wr_en;
   logic [CSR_IDX_W-1:0] idx;
   logic [HEIGHT_W-1:0] height_min_ff;
   logic [HEIGHT_W-1:0] height_max_ff;
   logic [SCALE_W-1:0]  hue_scale_ff;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         height_min_ff <= HEIGHT_MIN_RST;
         height_max_ff <= HEIGHT_MAX_RST;
         hue_scale_ff  <= HUE_SCALE_RST;
      end else if (wr_en) begin
         unique case (idx)
            CSR_HEIGHT_MIN: height_min_ff <= pwdata[HEIGHT_W-1:0];
            CSR_HEIGHT_MAX: height_max_ff <= pwdata[HEIGHT_W-1:0];
            CSR_HUE_SCALE:  hue_scale_ff  <= pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         CSR_HEIGHT_MIN: prdata = height_min_ff;
         CSR_HEIGHT_MAX: prdata = height_max_ff;
         CSR_HUE_SCALE:  prdata = CSR_DATA_W'(hue_scale_ff);
         default:        prdata = '0;
      endcase
   end

   assign height_min = height_min_ff;
   assign height_max = height_max_ff;
   assign hue_scale  = hue_scale_ff;

endmodule

`default_nettype wire

// ----- rtl/hhc_front.sv -----
`default_nettype none

module hhc_front
   import hhc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire logic [HEIGHT_W-1:0] height,
   input  wire logic [HEIGHT_W-1:0] height_min,
   input  wire logic [HEIGHT_W-1:0] height_max,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output      logic [DIFF_W-1:0]   num_mag,
   output      logic [DIFF_W-1:0]   den_mag,
   output      flags_type           flags
);

   logic              a_valid_ff;
   logic              b_valid_ff;
   logic              a_ready;
   logic              b_ready;
   logic [DIFF_W-1:0] num_ff;
   logic [DIFF_W-1:0] den_ff;
   logic [DIFF_W-1:0] num_in;
   logic [DIFF_W-1:0] den_in;
   logic [DIFF_W-1:0] an_ff;
   logic [DIFF_W-1:0] ad_ff;
   logic [DIFF_W-1:0] an_in;
   logic [DIFF_W-1:0] ad_in;
   flags_type         flags_ff;
   flags_type         flags_in;

   // stage handshake, a stage moves on when it is empty or its successor moves
   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   // stage a: signed differences against the low end of the range
   assign num_in = {height[HEIGHT_W-1], height} - {height_min[HEIGHT_W-1], height_min};
   assign den_in = {height_max[HEIGHT_W-1], height_max}
                   - {height_min[HEIGHT_W-1], height_min};

   always_ff @(posedge clock) begin
      if (a_ready) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // stage b: magnitudes and the sign and zero cases
   always_comb begin
      an_in               = num_ff[DIFF_W-1] ? -num_ff : num_ff;
      ad_in               = den_ff[DIFF_W-1] ? -den_ff : den_ff;
      flags_in.zero_range = (den_ff == '0);
      flags_in.t_zero     = (num_ff == '0) || (num_ff[DIFF_W-1] != den_ff[DIFF_W-1]);
      flags_in.sat        = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         an_ff    <= an_in;
         ad_ff    <= ad_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign num_mag   = an_ff;
   assign den_mag   = ad_ff;
   assign flags     = flags_ff;

endmodule

`default_nettype wire

// ----- rtl/hhc_div.sv -----
`default_nettype none

module hhc_div
   import hhc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [DIFF_W-1:0] num_mag,
   input  wire logic [DIFF_W-1:0] den_mag,
   input  wire flags_type         in_flags,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      logic [FRAC_W-1:0] quot,
   output      flags_type         out_flags
);

   // one range check stage, then one quotient bit per stage
   localparam int NSTAGE = FRAC_W + 1;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] rdy;
   logic [REM_W-1:0]  rem_ff   [NSTAGE];
   logic [FRAC_W-1:0] q_ff     [NSTAGE];
   logic [DIFF_W-1:0] ad_ff    [NSTAGE];
   flags_type         flags_ff [NSTAGE];
   flags_type         flags0_in;

   // ready chain, back to front
   always_comb begin
      rdy[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   // range check: a quotient of one or more saturates
   always_comb begin
      flags0_in     = in_flags;
      flags0_in.sat = (num_mag >= den_mag);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0]   <= {1'b0, num_mag};
         q_ff[0]     <= '0;
         ad_ff[0]    <= den_mag;
         flags_ff[0] <= flags0_in;
      end
   end

   // restoring division steps
   for (genvar k = 1; k < NSTAGE; k++) begin : g_step
      logic [REM_W-1:0] rem2;
      logic             ge;
      logic [REM_W-1:0] rem_in;

      always_comb begin
         rem2   = {rem_ff[k-1][REM_W-2:0], 1'b0};
         ge     = (rem2 >= {1'b0, ad_ff[k-1]});
         rem_in = ge ? rem2 - {1'b0, ad_ff[k-1]} : rem2;
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]   <= rem_in;
            q_ff[k]     <= {q_ff[k-1][FRAC_W-2:0], ge};
            ad_ff[k]    <= ad_ff[k-1];
            flags_ff[k] <= flags_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign quot      = q_ff[NSTAGE-1];
   assign out_flags = flags_ff[NSTAGE-1];

endmodule

`default_nettype wire

// ----- rtl/hhc_color.sv -----
`default_nettype none

module hhc_color
   import hhc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire logic [FRAC_W-1:0]  quot,
   input  wire flags_type          in_flags,
   input  wire logic [SCALE_W-1:0] hue_scale,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      logic [CHAN_W-1:0]  red,
   output      logic [CHAN_W-1:0]  green,
   output      logic [CHAN_W-1:0]  blue,
   output      logic               range_error
);

   localparam int NSTAGE = 4;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] rdy;
   logic [NSTAGE-1:0] zero_ff;

   logic [UNIT_W-1:0] t_val;
   logic [UNIT_W-1:0] inv_ff;
   logic [PROD_W-1:0] prod;
   logic [FRAC_W-1:0] hue_ff;
   logic [H6_W-1:0]   h6;
   sector_type        sector_in;
   sector_type        sector_ff;
   logic [UNIT_W-1:0] ramp_in;
   logic [UNIT_W-1:0] ramp_ff;
   logic [CHAN_FW-1:0] ramp_x255;
   logic [CHAN_W-1:0] nc;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;

   // ready chain, back to front
   always_comb begin
      rdy[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   // zero range flag follows the item
   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (rdy[i]) begin
            zero_ff[i] <= (i == 0) ? in_flags.zero_range : zero_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // stage 1: clamp the fraction and invert it
   always_comb begin
      priority if (in_flags.t_zero) begin
         t_val = '0;
      end else if (in_flags.sat) begin
         t_val = FRAC_ONE;
      end else begin
         t_val = {1'b0, quot};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         inv_ff <= FRAC_ONE - t_val;
      end
   end

   // stage 2: scale, keep the fractional hue
   assign prod = inv_ff * hue_scale;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         hue_ff <= prod[SCALE_FB +: FRAC_W];
      end
   end

   // stage 3: sector and ramp, ramp reversed in odd sectors
   always_comb begin
      h6        = {1'b0, hue_ff, 2'b00} + {2'b00, hue_ff, 1'b0};
      sector_in = sector_type'(h6[H6_W-1:FRAC_W]);
      ramp_in   = h6[FRAC_W] ? FRAC_ONE - {1'b0, h6[FRAC_W-1:0]}
                             : {1'b0, h6[FRAC_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         sector_ff <= sector_in;
         ramp_ff   <= ramp_in;
      end
   end

   // stage 4: ramp to channel and channel order
   always_comb begin
      ramp_x255 = {ramp_ff, CHAN_W'(0)} - CHAN_FW'(ramp_ff);
      nc        = ramp_x255[FRAC_W +: CHAN_W];
      unique case (sector_ff)
         SEC_RED: begin
            red_in = CHAN_FULL; green_in = nc;        blue_in = CHAN_ZERO;
         end
         SEC_YELLOW: begin
            red_in = nc;        green_in = CHAN_FULL; blue_in = CHAN_ZERO;
         end
         SEC_GREEN: begin
            red_in = CHAN_ZERO; green_in = CHAN_FULL; blue_in = nc;
         end
         SEC_CYAN: begin
            red_in = CHAN_ZERO; green_in = nc;        blue_in = CHAN_FULL;
         end
         SEC_BLUE: begin
            red_in = nc;        green_in = CHAN_ZERO; blue_in = CHAN_FULL;
         end
         default: begin
            red_in = CHAN_FULL; green_in = CHAN_ZERO; blue_in = nc;
         end
      endcase
      if (zero_ff[2]) begin
         red_in   = FB_RED;
         green_in = FB_GREEN;
         blue_in  = FB_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid   = valid_ff[NSTAGE-1];
   assign red         = red_ff;
   assign green       = green_ff;
   assign blue        = blue_ff;
   assign range_error = zero_ff[NSTAGE-1];

   // fallback colour goes with the range flag
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      out_valid && range_error |-> red == FB_RED && green == FB_GREEN && blue == FB_BLUE)
      else $error("fallback colour missing on zero range");

   // a normal colour always has one full channel
   a_full_chan: assert property (@(posedge clock) disable iff (reset)
      out_valid && !range_error |-> red == CHAN_FULL || green == CHAN_FULL
                                    || blue == CHAN_FULL)
      else $error("no full channel in colour");

   // and always one dark channel
   a_zero_chan: assert property (@(posedge clock) disable iff (reset)
      out_valid && !range_error |-> red == CHAN_ZERO || green == CHAN_ZERO
                                    || blue == CHAN_ZERO)
      else $error("no zero channel in colour");

endmodule

`default_nettype wire

// ----- rtl/height_to_hue_color_top.sv -----
`default_nettype none

// channel   direction  payload                          handshake
// req       in         height (s32, Q16.16)             valid / ready
// rsp       out        red, green, blue (u8), range_error valid / ready
// csr       in         height_min, height_max, hue_scale  APB write, pready tied high
//
// one item per cycle sustained while the rsp side does not stall; 23 register
// stages lie between req and rsp
// the divider has one quotient bit per stage over 16 stages, and there are
// two front stages, one range check stage and four colour stages
// every stage holds its own valid bit and fills whenever it is empty, so a
// stalled rsp side lets the pipe close its bubbles before req ready drops
// reset is synchronous and clears the valid bits and the configuration registers

module height_to_hue_color_top
   import hhc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   hhc_req_if.sink                    req_port,
   hhc_rsp_if.source                  rsp_port,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   logic [HEIGHT_W-1:0] height_min;
   logic [HEIGHT_W-1:0] height_max;
   logic [SCALE_W-1:0]  hue_scale;

   logic                fr_valid;
   logic                fr_ready;
   logic [DIFF_W-1:0]   num_mag;
   logic [DIFF_W-1:0]   den_mag;
   flags_type           fr_flags;

   logic                dv_valid;
   logic                dv_ready;
   logic [FRAC_W-1:0]   quot;
   flags_type           dv_flags;

   // configuration registers
   hhc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .height_min (height_min),
      .height_max (height_max),
      .hue_scale  (hue_scale)
   );

   // differences and magnitudes
   hhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_port.valid),
      .in_ready   (req_port.ready),
      .height     (req_port.height),
      .height_min (height_min),
      .height_max (height_max),
      .out_valid  (fr_valid),
      .out_ready  (fr_ready),
      .num_mag    (num_mag),
      .den_mag    (den_mag),
      .flags      (fr_flags)
   );

   // normalised height by pipelined division
   hhc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .num_mag   (num_mag),
      .den_mag   (den_mag),
      .in_flags  (fr_flags),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .quot      (quot),
      .out_flags (dv_flags)
   );

   // hue and colour
   hhc_color u_color (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_ready    (dv_ready),
      .quot        (quot),
      .in_flags    (dv_flags),
      .hue_scale   (hue_scale),
      .out_valid   (rsp_port.valid),
      .out_ready   (rsp_port.ready),
      .red         (rsp_port.red),
      .green       (rsp_port.green),
      .blue        (rsp_port.blue),
      .range_error (rsp_port.range_error)
   );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import hhc_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int PIPE_LATENCY   = 23;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int PHASE_COUNT    = 14;
   localparam int PHASE_ITEMS    = 75;
   localparam int HOLD_PHASE     = 3;
   localparam int HOLD_CYCLES    = 150;
   localparam int SECTOR_COUNT   = 6;

   localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_W) - 1;

   // register slot past the last one, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [HEIGHT_W-1:0] H_LOWEST  = 32'sh8000_0000;
   localparam logic signed [HEIGHT_W-1:0] H_HIGHEST = 32'sh7FFF_FFFF;
   localparam logic signed [HEIGHT_W-1:0] H_ONE     = 32'sh0001_0000;
   localparam logic signed [HEIGHT_W-1:0] H_TEN     = 32'sh000A_0000;
   localparam logic signed [HEIGHT_W-1:0] H_NEG_TEN = 32'shFFF6_0000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              range_error;
   } colour_type;

   localparam colour_type NOT_TYPED = '0;
   localparam colour_type PURE_RED  = '{CHAN_FULL, CHAN_ZERO, CHAN_ZERO, 1'b0};
   localparam colour_type DEFAULT_T0 = '{8'd203, CHAN_ZERO, CHAN_FULL, 1'b0};
   localparam colour_type FALLBACK  = '{FB_RED, FB_GREEN, FB_BLUE, 1'b1};

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] lo;
      logic signed [HEIGHT_W-1:0] hi;
      logic [SCALE_W-1:0]         scale;
      logic signed [HEIGHT_W-1:0] height;
      logic                       typed;
      colour_type                 want;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   // settings and heights for the opening part, typed colours where obvious
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // reset range 0..1 m, default hue factor
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, 32'sd0,     1'b1, DEFAULT_T0},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, H_ONE,      1'b1, PURE_RED},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, 32'sd32768, 1'b0, NOT_TYPED},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, H_HIGHEST,  1'b1, PURE_RED},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, H_LOWEST,   1'b1, DEFAULT_T0},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, -32'sd1,    1'b1, DEFAULT_T0},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, HUE_SCALE_RST, 32'sd1,     1'b0, NOT_TYPED},
      // widest range, largest hue factor
      '{H_LOWEST, H_HIGHEST, 16'hFFFF, H_LOWEST,  1'b0, NOT_TYPED},
      '{H_LOWEST, H_HIGHEST, 16'hFFFF, H_HIGHEST, 1'b0, NOT_TYPED},
      '{H_LOWEST, H_HIGHEST, 16'hFFFF, 32'sd0,    1'b0, NOT_TYPED},
      '{H_LOWEST, H_HIGHEST, 16'hFFFF, -32'sd1,   1'b0, NOT_TYPED},
      // inverted range, colours run backwards
      '{H_TEN, H_NEG_TEN, HUE_SCALE_RST, 32'sd0,    1'b0, NOT_TYPED},
      '{H_TEN, H_NEG_TEN, HUE_SCALE_RST, H_TEN,     1'b0, NOT_TYPED},
      '{H_TEN, H_NEG_TEN, HUE_SCALE_RST, H_NEG_TEN, 1'b0, NOT_TYPED},
      '{H_TEN, H_NEG_TEN, HUE_SCALE_RST, H_HIGHEST, 1'b0, NOT_TYPED},
      '{H_TEN, H_NEG_TEN, HUE_SCALE_RST, H_LOWEST,  1'b0, NOT_TYPED},
      // zero range gives the fallback colour
      '{32'sd12345, 32'sd12345, HUE_SCALE_RST, 32'sd0,    1'b1, FALLBACK},
      '{32'sd12345, 32'sd12345, HUE_SCALE_RST, H_HIGHEST, 1'b1, FALLBACK},
      '{H_LOWEST,   H_LOWEST,   HUE_SCALE_RST, H_LOWEST,  1'b1, FALLBACK},
      // zero hue factor pins the hue at red
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, 16'd0, 32'sd0,     1'b1, PURE_RED},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, 16'd0, 32'sd32768, 1'b1, PURE_RED},
      // hue factor of one wraps a full turn back to red
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, 16'd32768, 32'sd0,     1'b1, PURE_RED},
      '{HEIGHT_MIN_RST, HEIGHT_MAX_RST, 16'd32768, 32'sd16384, 1'b0, NOT_TYPED},
      // smallest non-zero range
      '{32'sd0, 32'sd1, 16'hFFFF, 32'sd0, 1'b0, NOT_TYPED},
      '{32'sd0, 32'sd1, 16'hFFFF, 32'sd1, 1'b0, NOT_TYPED}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hhc_req_if req_ch ();
   hhc_rsp_if rsp_ch ();

   // register copies used by the colour predictor
   logic signed [HEIGHT_W-1:0] cfg_min   = HEIGHT_MIN_RST;
   logic signed [HEIGHT_W-1:0] cfg_max   = HEIGHT_MAX_RST;
   logic [SCALE_W-1:0]         cfg_scale = HUE_SCALE_RST;

   // side payload travelling with each offered item
   logic       item_typed;
   colour_type item_want;

   colour_type expected_colours [$];
   int         failures      = 0;
   bit         req_idle_on   = 1'b1;
   bit         rsp_idle_on   = 1'b1;
   bit         hold_request  = 1'b0;

   height_to_hue_color_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch.sink),
      .rsp_port (rsp_ch.source),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // colour a height against a given range and hue factor
   function automatic colour_type predict_colour(logic signed [HEIGHT_W-1:0] height,
                                                 logic signed [HEIGHT_W-1:0] lo,
                                                 logic signed [HEIGHT_W-1:0] hi,
                                                 logic [SCALE_W-1:0] scale);
      longint          num;
      longint          den;
      longint unsigned mag_num;
      longint unsigned mag_den;
      longint unsigned level;
      longint unsigned inv;
      longint unsigned hue;
      longint unsigned hue6;
      longint unsigned ramp;
      longint unsigned ramp_chan;
      sector_type      sector;
      colour_type      c;
      num = longint'(height) - longint'(lo);
      den = longint'(hi) - longint'(lo);
      if (den == 0) begin
         return FALLBACK;
      end
      // clamp below zero by sign, above one by saturation
      if (num == 0 || ((num < 0) != (den < 0))) begin
         level = 0;
      end else begin
         mag_num = (num < 0) ? -num : num;
         mag_den = (den < 0) ? -den : den;
         level   = (mag_num << FRAC_W) / mag_den;
         if (level > FRAC_ONE) level = FRAC_ONE;
      end
      inv    = FRAC_ONE - level;
      hue    = ((inv * scale) >> SCALE_FB) & FRAC_MASK;
      hue6   = hue * SECTOR_COUNT;
      sector = sector_type'(3'(hue6 >> FRAC_W));
      ramp   = hue6 & FRAC_MASK;
      // ramp falls through odd sectors
      if (sector[0]) ramp = FRAC_ONE - ramp;
      ramp_chan = (ramp * CHAN_FULL) >> FRAC_W;
      c.range_error = 1'b0;
      case (sector)
         SEC_RED: begin
            c.red = CHAN_FULL; c.green = ramp_chan[CHAN_W-1:0]; c.blue = CHAN_ZERO;
         end
         SEC_YELLOW: begin
            c.red = ramp_chan[CHAN_W-1:0]; c.green = CHAN_FULL; c.blue = CHAN_ZERO;
         end
         SEC_GREEN: begin
            c.red = CHAN_ZERO; c.green = CHAN_FULL; c.blue = ramp_chan[CHAN_W-1:0];
         end
         SEC_CYAN: begin
            c.red = CHAN_ZERO; c.green = ramp_chan[CHAN_W-1:0]; c.blue = CHAN_FULL;
         end
         SEC_BLUE: begin
            c.red = ramp_chan[CHAN_W-1:0]; c.green = CHAN_ZERO; c.blue = CHAN_FULL;
         end
         default: begin
            c.red = CHAN_FULL; c.green = CHAN_ZERO; c.blue = ramp_chan[CHAN_W-1:0];
         end
      endcase
      return c;
   endfunction

   // append one prediction at the tail of the queue
   function automatic void queue_expected(colour_type c);
      expected_colours.insert(expected_colours.size(), c);
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int idle_gap(bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // heights mostly inside the current range, some at its ends, some anywhere
   function automatic logic signed [HEIGHT_W-1:0] pick_height();
      longint                     span;
      longint                     pick;
      longint unsigned            mag;
      longint unsigned            offset;
      logic signed [HEIGHT_W-1:0] boundary;
      int                         roll;
      roll = $urandom_range(0, 9);
      span = longint'(cfg_max) - longint'(cfg_min);
      if (roll < 2 || span == 0) return $urandom;
      if (roll == 2) begin
         boundary = $urandom_range(0, 1) ? cfg_max : cfg_min;
         return boundary + HEIGHT_W'($urandom_range(0, 2)) - HEIGHT_W'(1);
      end
      mag    = (span < 0) ? -span : span;
      offset = {$urandom, $urandom} % (mag + 1);
      pick   = (span < 0) ? longint'(cfg_min) - longint'(offset)
                          : longint'(cfg_min) + longint'(offset);
      return pick[HEIGHT_W-1:0];
   endfunction

   // apb write, entered and left at a falling edge
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         CSR_HEIGHT_MIN: cfg_min   = value;
         CSR_HEIGHT_MAX: cfg_max   = value;
         CSR_HUE_SCALE:  cfg_scale = value[SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // stop offering and let every outstanding colour drain
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_colours.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_setting(input logic signed [HEIGHT_W-1:0] lo,
                                input logic signed [HEIGHT_W-1:0] hi,
                                input logic [SCALE_W-1:0] scale);
      wait_idle();
      csr_write(CSR_HEIGHT_MIN, lo);
      csr_write(CSR_HEIGHT_MAX, hi);
      csr_write(CSR_HUE_SCALE, CSR_DATA_W'(scale));
   endtask

   // offer one height, return at the falling edge after it is taken and any idle gap
   task automatic send_height(input logic signed [HEIGHT_W-1:0] height,
                              input logic typed, input colour_type want);
      int gap;
      req_ch.valid  <= 1'b1;
      req_ch.height <= height;
      item_typed    <= typed;
      item_want     <= want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      gap = idle_gap(req_idle_on);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // random range, direction and hue factor for one phase
   task automatic randomise_setting();
      logic signed [HEIGHT_W-1:0] lo;
      logic signed [HEIGHT_W-1:0] hi;
      logic signed [HEIGHT_W-1:0] span;
      logic [SCALE_W-1:0]         scale;
      int                         roll;
      roll = $urandom_range(0, 11);
      case (roll)
         0: begin
            lo = $urandom; hi = lo;
         end
         1: begin
            lo = H_LOWEST; hi = H_HIGHEST;
         end
         2: begin
            lo = H_HIGHEST; hi = H_LOWEST;
         end
         3, 4: begin
            lo = $urandom; hi = $urandom;
         end
         default: begin
            lo   = $urandom;
            lo   = lo >>> $urandom_range(0, 16);
            span = $urandom_range(1, 1 << 20);
            hi   = roll[0] ? lo + span : lo - span;
         end
      endcase
      case ($urandom_range(0, 5))
         0: scale = HUE_SCALE_RST;
         1: scale = '0;
         2: scale = '1;
         3: scale = SCALE_W'(32768);
         default: scale = $urandom;
      endcase
      apply_setting(lo, hi, scale);
   endtask

   // predict each accepted height
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         queue_expected(item_typed ? item_want
                        : predict_colour(req_ch.height, cfg_min, cfg_max, cfg_scale));
      end
   end

   // compare each accepted colour with the oldest prediction
   always @(posedge clock) begin : check_colours
      colour_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_colours.size() == 0) begin
            $error("colour item with no prediction waiting");
            failures++;
         end else begin
            want = expected_colours.pop_front();
            if (rsp_ch.red !== want.red) begin
               $error("red: expected %0d, actual %0d", want.red, rsp_ch.red);
               failures++;
            end
            if (rsp_ch.green !== want.green) begin
               $error("green: expected %0d, actual %0d", want.green, rsp_ch.green);
               failures++;
            end
            if (rsp_ch.blue !== want.blue) begin
               $error("blue: expected %0d, actual %0d", want.blue, rsp_ch.blue);
               failures++;
            end
            if (rsp_ch.range_error !== want.range_error) begin
               $error("range_error: expected %0d, actual %0d", want.range_error,
                      rsp_ch.range_error);
               failures++;
            end
         end
      end
   end

   // result side: bursts of ready, random stalls, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin : ready_pattern
         int gap;
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         gap = idle_gap(rsp_idle_on);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAIL");
      $finish;
   end

   // reset, opening table, random phases, drain
   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.height = '0;
      item_typed    = 1'b0;
      item_want     = NOT_TYPED;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a write past the last register must leave the reset setting alone
      csr_write(CSR_SPARE, $urandom);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].lo != cfg_min || DIRECTED_ROWS[i].hi != cfg_max ||
             DIRECTED_ROWS[i].scale != cfg_scale) begin
            apply_setting(DIRECTED_ROWS[i].lo, DIRECTED_ROWS[i].hi, DIRECTED_ROWS[i].scale);
         end
         send_height(DIRECTED_ROWS[i].height, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         randomise_setting();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         // one phase of back-to-back items against a stalled result side
         if (phase == HOLD_PHASE) begin
            req_idle_on  = 1'b0;
            hold_request = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_height(pick_height(), 1'b0, NOT_TYPED);
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
